// File: sv/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    // Default width of the input number; the result is one bit wider.
    localparam int NPS_VALUE_WIDTH = 32;

    // Sequencer states of the search.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    // Control from the sequencer to the shared divider.
    typedef struct packed {
        logic start;
        logic hold;
    } div_ctl_t;

    // Status from the shared divider back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// File: sv/nps_number_if.sv
`timescale 1ns / 1ps

interface nps_number_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

// File: sv/nps_prime_if.sv
`timescale 1ns / 1ps

interface nps_prime_if #(
    parameter int W = 33
);
    logic         valid;
    logic         ready;
    logic [W-1:0] next_prime;

    modport source (output valid, output next_prime, input ready);
    modport sink   (input valid, input next_prime, output ready);
endinterface

// File: sv/nps_divider.sv
`timescale 1ns / 1ps

module nps_divider #(
    parameter int W = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nps_pkg::div_ctl_t ctl,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    output nps_pkg::div_sts_t sts,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    import nps_pkg::*;

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;

    // Restoring division, one quotient bit per cycle while hold is low.
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start && !busy_reg)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg && !ctl.hold)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/next_prime_search.sv
`timescale 1ns / 1ps

// Returns the smallest prime strictly greater than each request's number, as
// a result one bit wider than the input so that it can never overflow. An
// input of zero answers 2. Candidates are tried upward from number+1; even
// candidates above 2 are skipped without dividing, and odd ones are tested by
// trial division with odd divisors 3, 5, 7 and so on until the divisor exceeds
// the quotient. All divisions go through one shared restoring divider that
// produces one quotient bit per cycle; a single trial division consists of a
// start, VALUE_WIDTH+1 bit steps and a completion. The time for one request
// therefore grows with the number of trial divisions summed over every odd
// candidate tried; a large prime near 2^32 needs about 33000 divisions. One
// request is worked on at a time: the input is ready only while the
// sequencer is idle. A finished result sits in an output register, so a new
// request can be taken while the previous result still waits for the
// downstream side. There is no configuration and no state kept between
// requests.

module next_prime_search #(
    parameter int VALUE_WIDTH = nps_pkg::NPS_VALUE_WIDTH
) (
    input logic        clk,
    input logic        rst_n,
    nps_number_if.sink in_chan,
    nps_prime_if.source out_chan
);
    import nps_pkg::*;

    localparam int CW = VALUE_WIDTH + 1;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cand_reg, cand_next;
    logic [CW-1:0]   dvs_reg, dvs_next;
    logic [CW-1:0]   res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;
    div_ctl_t        div_ctl;
    div_sts_t        div_sts;
    logic [CW-1:0]   quotient;
    logic [CW-1:0]   remainder;

    // The shared divider computes candidate / divisor.
    nps_divider #(
        .W(CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (cand_reg),
        .divisor   (dvs_reg),
        .sts       (div_sts),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // The output slot is free when empty or being emptied in this cycle.
    assign out_free = !out_valid_reg || out_chan.ready;

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        dvs_next       = dvs_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_chan.ready;
        div_ctl.start  = 1'b0;
        div_ctl.hold   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_chan.valid)
                begin
                    cand_next  = {1'b0, in_chan.number} + CW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // One is not prime, two and three are, and even candidates
                // of four or more are rejected without dividing.
                if (cand_reg < CW'(2) || (cand_reg >= CW'(4) && !cand_reg[0]))
                begin
                    cand_next = cand_reg + CW'(1);
                end
                else if (cand_reg < CW'(4))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dvs_next   = CW'(3);
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_ctl.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    if (dvs_reg > quotient)
                    begin
                        // The divisor has passed the square root: prime.
                        state_next = ST_DONE;
                    end
                    else if (remainder == '0)
                    begin
                        cand_next  = cand_reg + CW'(1);
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        dvs_next   = dvs_reg + CW'(2);
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next       = cand_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        dvs_reg  <= dvs_next;
        res_reg  <= res_next;
    end

    assign in_chan.ready       = (state_reg == ST_IDLE);
    assign out_chan.valid      = out_valid_reg;
    assign out_chan.next_prime = res_reg;

    // A division only ever completes while the sequencer is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == ST_DIV)
    else $error("divider finished outside the division state");

    // An accepted request always moves the sequencer into candidate checking.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_chan.valid && in_chan.ready) |=> state_reg == ST_CHECK)
    else $error("accepted request did not start a search");

    // Trial divisors are odd and at least three whenever a division starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_START |-> (dvs_reg >= CW'(3) && dvs_reg[0]))
    else $error("bad trial divisor");

    // A division is only started once the divider has finished the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_START |-> !div_sts.busy)
    else $error("division started while the divider was busy");

    // Every reported prime is two or odd.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg[0] || res_reg == CW'(2)))
    else $error("reported result is even and not two");

endmodule
